// ----- src/brs_pkg.sv -----
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the bilinear RGBA scaler
// Sizes, fixed-point format, request/result structs, queue entry and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // fixed-point format and image limits
  localparam int FRAC_BITS   = 16;
  localparam int MAX_SRC_W   = 512;
  localparam int MAX_SRC_H   = 512;
  localparam int SIZE_W      = 10;
  localparam int STEP_W      = 25;
  localparam int COORD_W     = 12;
  localparam int XW          = $clog2(MAX_SRC_W);
  localparam int YW          = $clog2(MAX_SRC_H);
  localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int LOAD_AW     = 18;
  localparam int POS_W       = COORD_W + STEP_W;
  localparam int IP_W        = POS_W - FRAC_BITS;
  localparam int NCH         = 4;
  localparam int CH_W        = 8;
  localparam int QDEPTH      = 4;

  // register indexes
  localparam logic [1:0] REG_SRC_W  = 2'd0;
  localparam logic [1:0] REG_SRC_H  = 2'd1;
  localparam logic [1:0] REG_X_STEP = 2'd2;
  localparam logic [1:0] REG_Y_STEP = 2'd3;

  // op codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_INTERP = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [LOAD_AW-1:0]   load_address;
    logic [31:0]          load_pixel;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
  } in_req_t;

  typedef struct packed {
    logic [31:0]        out_pixel;
    logic [COORD_W-1:0] echo_x;
    logic [COORD_W-1:0] echo_y;
  } out_res_t;

  // classified work handed from front to back
  typedef struct packed {
    logic               op;
    logic               wr_ok;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      addr_c;
    logic [AW-1:0]      addr_d;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [COORD_W-1:0] echo_x;
    logic [COORD_W-1:0] echo_y;
  } q_entry_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_ROW,
    FE_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RA,
    BK_RB,
    BK_RC,
    BK_RD,
    BK_WT,
    BK_HB,
    BK_VB
  } back_state_t;

endpackage

`default_nettype wire

// ----- src/bilinear_rgba_scaler_core.sv -----
// ----------------------------------------------------------------------------
// bilinear_rgba_scaler_core: bilinear RGBA image resize engine
// Load requests fill the source store; interpolate requests return one
// blended pixel each, in request order.
// ----------------------------------------------------------------------------
// A load request goes from accept straight to queue push; an interpolate
// request passes the front as accept, coordinate multiply, clamp and row
// address and queue push, and the back as queue pop, four neighbor reads
// through the single port of the source store and two blend stages. Front
// and back overlap through a 4-entry queue, so the front can take new
// requests while the back works; out_valid pulses for one cycle per result
// and results cannot be stalled. busy is high while the front works or the
// queue is full. The configuration port is always ready.
`default_nettype none

module bilinear_rgba_scaler_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire brs_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output brs_pkg::out_res_t      out_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  brs_pkg::q_entry_t push_data, head;
  logic q_push, q_pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  brs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  brs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  brs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // a taken request always raises busy, holding off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept not followed by busy");

  // results are single-cycle strobes, spaced by the read sequence
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  // reset kills any pending strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result strobe after reset");

  // a push never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue overflow");

endmodule

`default_nettype wire

// ----- src/brs_queue.sv -----
// ----------------------------------------------------------------------------
// brs_queue: short FIFO between front and back
// Register-based queue of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire brs_pkg::q_entry_t push_data,
  input  wire logic              pop,
  output brs_pkg::q_entry_t      head,
  output logic                   empty,
  output logic                   full
);

  localparam int PW = $clog2(brs_pkg::QDEPTH);
  localparam int CW = $clog2(brs_pkg::QDEPTH + 1);

  brs_pkg::q_entry_t slots_r [brs_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(brs_pkg::QDEPTH));
  assign head  = slots_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) slots_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full)  wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop && !empty)  rd_ptr_r <= rd_ptr_r + PW'(1);
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/brs_front.sv -----
// ----------------------------------------------------------------------------
// brs_front: request intake, configuration and neighbor address generation
// Scales coordinates by the step registers, clamps, builds store addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire brs_pkg::in_req_t  in_req,
  output logic                   busy,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output brs_pkg::q_entry_t      q_data
);

  localparam int FB = brs_pkg::FRAC_BITS;
  localparam int SW = brs_pkg::SIZE_W;
  localparam int XW = brs_pkg::XW;
  localparam int YW = brs_pkg::YW;
  localparam int AW = brs_pkg::AW;
  localparam int PW = brs_pkg::POS_W;
  localparam int IW = brs_pkg::IP_W;

  brs_pkg::front_state_t state_r, state_nxt;
  brs_pkg::in_req_t      item_r;

  logic [SW-1:0] w_r, h_r;
  logic [brs_pkg::STEP_W-1:0] xs_r, ys_r;
  logic [PW-1:0] pos_x_r, pos_y_r;
  logic [XW-1:0] x0_r, x1_r;
  logic [AW-1:0] row0_r, row1_r;
  logic [FB-1:0] fx_r, fy_r;

  logic          accept;
  logic [SW-1:0] cfg_clamped;
  logic [SW-1:0] wm1, hm1;
  logic [IW-1:0] ipx, ipy;
  logic [XW-1:0] x0_nxt, x1_nxt;
  logic [YW-1:0] y0_nxt, y1_nxt;
  logic [YW+SW-1:0] prod0, prod1;

  assign accept = start && !busy;

  // size write: only the low SW bits count; zero reads as one, values above the maximum saturate
  always_comb begin
    cfg_clamped = cfg_data[SW-1:0];
    if (cfg_data[SW-1:0] == '0) cfg_clamped = SW'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= SW'(2);
      h_r  <= SW'(2);
      xs_r <= '0;
      ys_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        brs_pkg::REG_SRC_W:
          w_r <= (cfg_clamped > SW'(brs_pkg::MAX_SRC_W)) ? SW'(brs_pkg::MAX_SRC_W)
                                                         : cfg_clamped;
        brs_pkg::REG_SRC_H:
          h_r <= (cfg_clamped > SW'(brs_pkg::MAX_SRC_H)) ? SW'(brs_pkg::MAX_SRC_H)
                                                         : cfg_clamped;
        brs_pkg::REG_X_STEP: xs_r <= cfg_data[brs_pkg::STEP_W-1:0];
        brs_pkg::REG_Y_STEP: ys_r <= cfg_data[brs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brs_pkg::FE_IDLE:
        if (accept) begin
          state_nxt = (in_req.op == brs_pkg::OP_LOAD) ? brs_pkg::FE_PUSH : brs_pkg::FE_MUL;
        end
      brs_pkg::FE_MUL:  state_nxt = brs_pkg::FE_ROW;
      brs_pkg::FE_ROW:  state_nxt = brs_pkg::FE_PUSH;
      brs_pkg::FE_PUSH: state_nxt = brs_pkg::FE_IDLE;
      default:          state_nxt = brs_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= brs_pkg::FE_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs: queue cannot fill between accept and push, front is the only writer
  always_comb begin
    busy   = (state_r != brs_pkg::FE_IDLE) || q_full;
    q_push = (state_r == brs_pkg::FE_PUSH);
  end

  // neighbor clamp at the right and bottom edges
  always_comb begin
    wm1 = w_r - SW'(1);
    hm1 = h_r - SW'(1);
    ipx = pos_x_r[PW-1:FB];
    ipy = pos_y_r[PW-1:FB];
    if (ipx >= IW'(wm1)) begin
      x0_nxt = wm1[XW-1:0];
      x1_nxt = wm1[XW-1:0];
    end else begin
      x0_nxt = ipx[XW-1:0];
      x1_nxt = ipx[XW-1:0] + XW'(1);
    end
    if (ipy >= IW'(hm1)) begin
      y0_nxt = hm1[YW-1:0];
      y1_nxt = hm1[YW-1:0];
    end else begin
      y0_nxt = ipy[YW-1:0];
      y1_nxt = ipy[YW-1:0] + YW'(1);
    end
    prod0 = (YW+SW)'(y0_nxt) * (YW+SW)'(w_r);
    prod1 = (YW+SW)'(y1_nxt) * (YW+SW)'(w_r);
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_req;
    if (state_r == brs_pkg::FE_MUL) begin
      pos_x_r <= PW'(item_r.out_x) * PW'(xs_r);
      pos_y_r <= PW'(item_r.out_y) * PW'(ys_r);
    end
    if (state_r == brs_pkg::FE_ROW) begin
      x0_r   <= x0_nxt;
      x1_r   <= x1_nxt;
      row0_r <= prod0[AW-1:0];
      row1_r <= prod1[AW-1:0];
      fx_r   <= pos_x_r[FB-1:0];
      fy_r   <= pos_y_r[FB-1:0];
    end
  end

  // queue entry
  always_comb begin
    q_data.op      = item_r.op;
    q_data.wr_ok   = ({1'b0, item_r.load_address} < (brs_pkg::LOAD_AW+1)'(brs_pkg::STORE_DEPTH));
    q_data.wr_addr = AW'(item_r.load_address);
    q_data.wr_data = item_r.load_pixel;
    q_data.addr_a  = row0_r + AW'(x0_r);
    q_data.addr_b  = row0_r + AW'(x1_r);
    q_data.addr_c  = row1_r + AW'(x0_r);
    q_data.addr_d  = row1_r + AW'(x1_r);
    q_data.fx      = fx_r;
    q_data.fy      = fy_r;
    q_data.echo_x  = item_r.out_x;
    q_data.echo_y  = item_r.out_y;
  end

endmodule

`default_nettype wire

// ----- src/brs_back.sv -----
// ----------------------------------------------------------------------------
// brs_back: source store and blend engine
// Writes loads, reads four neighbors through one port, blends per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire brs_pkg::q_entry_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  output brs_pkg::out_res_t      out_res
);

  localparam int FB  = brs_pkg::FRAC_BITS;
  localparam int AW  = brs_pkg::AW;
  localparam int CW  = brs_pkg::CH_W;
  localparam int NCH = brs_pkg::NCH;
  localparam int TW  = CW + FB + 1;
  localparam int VW  = TW + FB + 1;

  brs_pkg::back_state_t state_r, state_nxt;
  brs_pkg::q_entry_t    ent_r;

  logic [31:0] mem [brs_pkg::STORE_DEPTH];
  logic [31:0] rd_data_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [TW-1:0] top_r [NCH];
  logic [TW-1:0] bot_r [NCH];
  logic [TW-1:0] top_nxt [NCH];
  logic [TW-1:0] bot_nxt [NCH];
  logic [31:0]   pix_nxt;
  logic          out_valid_r;
  brs_pkg::out_res_t out_res_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [FB:0]   one_m_fx, one_m_fy;
  logic [VW-1:0] vsum;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brs_pkg::BK_IDLE:
        if (!q_empty && q_head.op == brs_pkg::OP_INTERP) state_nxt = brs_pkg::BK_RA;
      brs_pkg::BK_RA: state_nxt = brs_pkg::BK_RB;
      brs_pkg::BK_RB: state_nxt = brs_pkg::BK_RC;
      brs_pkg::BK_RC: state_nxt = brs_pkg::BK_RD;
      brs_pkg::BK_RD: state_nxt = brs_pkg::BK_WT;
      brs_pkg::BK_WT: state_nxt = brs_pkg::BK_HB;
      brs_pkg::BK_HB: state_nxt = brs_pkg::BK_VB;
      brs_pkg::BK_VB: state_nxt = brs_pkg::BK_IDLE;
      default:        state_nxt = brs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= brs_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  // memory port control
  always_comb begin
    q_pop   = (state_r == brs_pkg::BK_IDLE) && !q_empty;
    wr_en   = q_pop && (q_head.op == brs_pkg::OP_LOAD) && q_head.wr_ok;
    rd_en   = 1'b1;
    rd_addr = ent_r.addr_a;
    case (state_r)
      brs_pkg::BK_RA: rd_addr = ent_r.addr_a;
      brs_pkg::BK_RB: rd_addr = ent_r.addr_b;
      brs_pkg::BK_RC: rd_addr = ent_r.addr_c;
      brs_pkg::BK_RD: rd_addr = ent_r.addr_d;
      default:        rd_en   = 1'b0;
    endcase
  end

  // single-port source store
  always_ff @(posedge clk) begin
    if (wr_en)      mem[q_head.wr_addr] <= q_head.wr_data;
    else if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // neighbor capture, read data lands in the cycle after its address
  always_ff @(posedge clk) begin
    if (q_pop) ent_r <= q_head;
    case (state_r)
      brs_pkg::BK_RB: a_r <= rd_data_r;
      brs_pkg::BK_RC: b_r <= rd_data_r;
      brs_pkg::BK_RD: c_r <= rd_data_r;
      brs_pkg::BK_WT: d_r <= rd_data_r;
      default: ;
    endcase
  end

  // horizontal blend
  always_comb begin
    one_m_fx = (FB+1)'(1 << FB) - (FB+1)'(ent_r.fx);
    one_m_fy = (FB+1)'(1 << FB) - (FB+1)'(ent_r.fy);
    for (int k = 0; k < NCH; k++) begin
      top_nxt[k] = TW'(a_r[k*CW +: CW]) * TW'(one_m_fx) + TW'(b_r[k*CW +: CW]) * TW'(ent_r.fx);
      bot_nxt[k] = TW'(c_r[k*CW +: CW]) * TW'(one_m_fx) + TW'(d_r[k*CW +: CW]) * TW'(ent_r.fx);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == brs_pkg::BK_HB) begin
      for (int k = 0; k < NCH; k++) begin
        top_r[k] <= top_nxt[k];
        bot_r[k] <= bot_nxt[k];
      end
    end
  end

  // vertical blend, truncate each channel
  always_comb begin
    pix_nxt = '0;
    vsum    = '0;
    for (int k = 0; k < NCH; k++) begin
      vsum = VW'(top_r[k]) * VW'(one_m_fy) + VW'(bot_r[k]) * VW'(ent_r.fy);
      pix_nxt[k*CW +: CW] = vsum[2*FB +: CW];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (state_r == brs_pkg::BK_VB);
    if (state_r == brs_pkg::BK_VB) begin
      out_res_r.out_pixel <= pix_nxt;
      out_res_r.echo_x    <= ent_r.echo_x;
      out_res_r.echo_y    <= ent_r.echo_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire
